// File: sv/b64e_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64e_pkg: shared types and constants for the Base64 encoder
// Holds the character job passed from the front end to the back end and the
// 6-bit to ASCII mapping of the standard alphabet.
// ---------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned JobChars = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam logic [5:0] SIX_MASK = 6'h3F;

    // position within the 3-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // characters caused by one input byte
    typedef struct packed {
        logic [JobChars-1:0][7:0] chars;  // chars[0] goes out first
        logic [1:0]               n;      // number of characters minus one
        logic                     last;   // final character ends the string
    } t_job;

    // 6-bit group to Base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [5:0] s;
        s = six & SIX_MASK;
        if (s < 6'd26)      return 8'(8'h41 + {2'b00, s});
        else if (s < 6'd52) return 8'(8'h61 + {2'b00, s} - 8'd26);
        else if (s < 6'd62) return 8'(8'h30 + {2'b00, s} - 8'd52);
        else if (s == 6'd62) return 8'h2B;  // '+'
        else                 return 8'h2F;  // '/'
    endfunction

endpackage

// File: sv/b64e_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64e_front: byte intake and group tracking
// Takes one byte per word, keeps the group phase and leftover bits, and
// builds the job of one to four characters that the byte causes.
// ---------------------------------------------------------------------------
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic            i_full,
    output logic            o_stall,
    output logic            o_push,
    output b64e_pkg::t_job  o_job
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    // next state and job contents
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        o_job.chars = '{default: PAD_CHAR};
        o_job.n     = 2'd0;
        o_job.last  = i_last_byte;
        unique case (r_phase)
            PH_1: begin
                o_job.chars[0] = b64_char({r_left[1:0], i_data_byte[7:4]});
                if (i_last_byte) begin
                    o_job.chars[1] = b64_char({i_data_byte[3:0], 2'b00});
                    o_job.n        = 2'd2;
                end
                n_phase = PH_2;
                n_left  = i_data_byte[3:0];
            end
            PH_2: begin
                o_job.chars[0] = b64_char({r_left, i_data_byte[7:6]});
                o_job.chars[1] = b64_char(i_data_byte[5:0]);
                o_job.n        = 2'd1;
                n_phase        = PH_0;
                n_left         = 4'd0;
            end
            default: begin
                o_job.chars[0] = b64_char(i_data_byte[7:2]);
                if (i_last_byte) begin
                    o_job.chars[1] = b64_char({i_data_byte[1:0], 4'b0000});
                    o_job.n        = 2'd3;
                end
                n_phase = PH_1;
                n_left  = {2'b00, i_data_byte[1:0]};
            end
        endcase
        if (!o_push) begin
            n_phase = r_phase;
            n_left  = r_left;
        end else if (i_last_byte) begin
            n_phase = PH_0;
            n_left  = 4'd0;
        end
    end

    // a string end restarts the group
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_last_byte |=> r_phase == PH_0 && r_left == 4'd0)
        else $error("group not restarted after last byte");

    // phase 2 always leaves a whole group behind
    a_ph2_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && r_phase == PH_2 |=> r_phase == PH_0)
        else $error("phase 2 did not wrap");

endmodule

// File: sv/b64e_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64e_queue: two-entry job queue
// Decouples the byte intake from the character output so that each side
// can stall on its own.
// ---------------------------------------------------------------------------
module b64e_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64e_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output b64e_pkg::t_job  o_head
);
    import b64e_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    assign o_full     = r_count == 2'd2;
    assign o_nonempty = r_count != 2'd0;
    assign o_head     = r_mem[r_rptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)      n_count = 2'(r_count + 2'd1);
        else if (!i_push && i_pop) n_count = 2'(r_count - 2'd1);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nonempty))
        else $error("pop from empty queue");

endmodule

// File: sv/b64e_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64e_back: character sequencer and output register
// Walks the characters of the head job one per word and holds the current
// character in the output register until it is taken.
// ---------------------------------------------------------------------------
module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  b64e_pkg::t_job  i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_char,
    output logic            o_out_last
);
    import b64e_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [1:0] r_idx, n_idx;
    logic       w_load, w_end;

    assign w_load = !r_valid || !i_stall;
    assign w_end  = r_idx == i_head.n;
    assign o_pop  = w_load && i_nonempty && w_end;

    assign o_valid    = r_valid;
    assign o_out_char = r_char;
    assign o_out_last = r_last;

    // index of next character within the head job
    always_comb begin
        n_idx = r_idx;
        if (w_load && i_nonempty) n_idx = w_end ? 2'd0 : 2'(r_idx + 2'd1);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (w_load) r_valid <= i_nonempty;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load && i_nonempty) begin
            r_char <= i_head.chars[r_idx];
            r_last <= i_head.last && w_end;
        end
    end

    // sequencer never runs past the job's character count
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_nonempty |-> r_idx <= i_head.n)
        else $error("character index beyond job");

    // index restarts whenever a job is retired
    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == 2'd0)
        else $error("index not reset after job");

endmodule

// File: sv/base64_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_encoder: streaming Base64 encoder, standard alphabet with padding
// Path: a byte's job is written into the job queue, and its characters are
//   then loaded one at a time into the output register.
// Throughput: one character per cycle while i_stall is low, set by the single
//   output register; a byte gives one or two characters, up to four if last.
// Reset: synchronous active-low; clears group phase, queue and output valid.
// ---------------------------------------------------------------------------
module base64_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    input  logic       i_stall
);
    import b64e_pkg::*;

    t_job w_push_job, w_head;
    logic w_push, w_pop, w_full, w_nonempty;

    // byte intake
    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // job queue
    b64e_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    // character output
    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

endmodule
